// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the flat shading RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define FDL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, off during reset
`define FDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/fdl_pkg.sv =====
// ----------------------------------------------------------------------------
// fdl_pkg
// Types, constants and step functions of the flat diffuse light shader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdl_pkg;

  localparam int SQ_STAGES  = 32;  // one root bit per stage
  localparam int DIV_STAGES = 17;  // one quotient bit per stage

  typedef enum logic [1:0] {
    ACT_NORM_BOTH = 2'd0,
    ACT_CLAMP     = 2'd1,
    ACT_BASE      = 2'd2,
    ACT_CLAMP_ALT = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_LIGHT_X      = 3'd0,
    REG_LIGHT_Y      = 3'd1,
    REG_LIGHT_Z      = 3'd2,
    REG_LIGHT_OFFSET = 3'd3,
    REG_LIGHT_AMP    = 3'd4,
    REG_BASE_COLOR   = 3'd5,
    REG_MIN_FACTOR   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] light_x;
    logic signed [31:0] light_y;
    logic signed [31:0] light_z;
    logic signed [31:0] light_offset;
    logic        [31:0] light_amp;
    logic        [15:0] base_color;
    logic signed [16:0] min_factor;
  } cfg_t;

  typedef struct packed {
    logic        [63:0] q;
    logic        [31:0] qn;
    logic signed [49:0] dot;
    action_e            action;
    logic               fzero;
  } front_out_t;

  typedef struct packed {
    logic signed [49:0] dot;
    action_e            action;
    logic               fzero;
  } sq_side_t;

  typedef struct packed {
    logic    neg;
    action_e action;
    logic    fzero;
  } div_side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [16:0] quo;
  } div_st_t;

  // position of the highest set bit, zero for an empty word
  function automatic logic [4:0] msb_pos(logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // decide root bit k: try root | 2^k against the remaining radicand
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int k);
    sqrt_st_t   r;
    logic [64:0] trial;
    trial = ({33'b0, s.root} << (k + 1)) + (65'd1 << (2 * k));
    r = s;
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[63:0];
      r.root = s.root | (32'd1 << k);
    end
    return r;
  endfunction

  // restoring division, quotient bit k
  function automatic div_st_t div_step(div_st_t s, logic [47:0] den, int k);
    div_st_t     r;
    logic [64:0] sub;
    sub = {17'b0, den} << k;
    r = s;
    if ({1'b0, s.rem} >= sub) begin
      r.rem    = s.rem - sub[63:0];
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fdl_front.sv =====
// ----------------------------------------------------------------------------
// fdl_front
// Light vector, normalizing shifts, squares and dot product in six stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdl_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire fdl_pkg::action_e    action_i,
  input  wire logic signed [31:0]  vertex_x_i,
  input  wire logic signed [31:0]  vertex_y_i,
  input  wire logic signed [31:0]  vertex_z_i,
  input  wire logic signed [15:0]  normal_x_i,
  input  wire logic signed [15:0]  normal_y_i,
  input  wire logic signed [15:0]  normal_z_i,
  input  wire fdl_pkg::cfg_t       cfg_i,
  output logic                     valid_o,
  output fdl_pkg::front_out_t      out_o
);

  logic [5:0] vld_q;

  logic signed [31:0] vtx   [3];
  logic signed [31:0] lgt   [3];
  logic signed [15:0] nin   [3];

  // stage 1
  fdl_pkg::action_e   act1_q;
  logic signed [32:0] d1_q  [3];
  logic signed [15:0] n1_q  [3];

  // stage 2
  logic signed [32:0] dng   [3];
  logic signed [16:0] nng   [3];
  logic        [31:0] amag  [3];
  logic        [15:0] bmag  [3];
  fdl_pkg::action_e   act2_q;
  logic        [31:0] a2_q  [3];
  logic        [2:0]  dneg2_q;
  logic signed [15:0] n2_q  [3];
  logic        [31:0] ord2_q;
  logic        [15:0] orn2_q;

  // stage 3
  logic [4:0]         dpos;
  logic [4:0]         npos;
  fdl_pkg::action_e   act3_q;
  logic        [31:0] a3_q  [3];
  logic        [2:0]  dneg3_q;
  logic signed [15:0] n3_q  [3];
  logic               dshr3_q;
  logic        [4:0]  dshl3_q;
  logic        [3:0]  nshl3_q;
  logic               dzero3_q;
  logic               nzero3_q;

  // stage 4
  logic        [31:0] ash   [3];
  logic signed [31:0] epos  [3];
  logic signed [15:0] nsc   [3];
  logic signed [16:0] nscn  [3];
  fdl_pkg::action_e   act4_q;
  logic        [30:0] a4_q  [3];
  logic signed [31:0] e4_q  [3];
  logic signed [15:0] nd4_q [3];
  logic        [15:0] b4_q  [3];
  logic               fz4_q;

  // stage 5
  fdl_pkg::action_e   act5_q;
  logic        [61:0] sq5_q [3];
  logic        [31:0] nq5_q [3];
  logic signed [47:0] p5_q  [3];
  logic               fz5_q;

  always_comb begin
    vtx[0] = vertex_x_i;
    vtx[1] = vertex_y_i;
    vtx[2] = vertex_z_i;
    lgt[0] = cfg_i.light_x;
    lgt[1] = cfg_i.light_y;
    lgt[2] = cfg_i.light_z;
    nin[0] = normal_x_i;
    nin[1] = normal_y_i;
    nin[2] = normal_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dng[i]  = -d1_q[i];
      amag[i] = d1_q[i][32] ? dng[i][31:0] : d1_q[i][31:0];
      nng[i]  = -{n1_q[i][15], n1_q[i]};
      bmag[i] = n1_q[i][15] ? nng[i][15:0] : n1_q[i];
    end
    dpos = fdl_pkg::msb_pos(ord2_q);
    npos = fdl_pkg::msb_pos({16'b0, orn2_q});
    for (int i = 0; i < 3; i++) begin
      ash[i]  = dshr3_q ? (a3_q[i] >> 1) : (a3_q[i] << dshl3_q);
      epos[i] = {1'b0, ash[i][30:0]};
      nsc[i]  = n3_q[i] <<< nshl3_q;
      nscn[i] = -{nsc[i][15], nsc[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act1_q <= action_i;
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= 33'(vtx[i]) - 33'(lgt[i]);
        n1_q[i] <= nin[i];
      end

      act2_q <= act1_q;
      for (int i = 0; i < 3; i++) begin
        a2_q[i]    <= amag[i];
        dneg2_q[i] <= d1_q[i][32];
        n2_q[i]    <= n1_q[i];
      end
      ord2_q <= amag[0] | amag[1] | amag[2];
      orn2_q <= bmag[0] | bmag[1] | bmag[2];

      // bring the largest magnitude into [2^30, 2^31), the normal into [2^14, 2^15]
      act3_q   <= act2_q;
      a3_q     <= a2_q;
      dneg3_q  <= dneg2_q;
      n3_q     <= n2_q;
      dshr3_q  <= ord2_q[31];
      dshl3_q  <= ord2_q[31] ? 5'd0 : 5'd30 - dpos;
      nshl3_q  <= orn2_q[15] ? 4'd0 : 4'(5'd14 - npos);
      dzero3_q <= (ord2_q == '0);
      nzero3_q <= (orn2_q == '0);

      act4_q <= act3_q;
      for (int i = 0; i < 3; i++) begin
        a4_q[i]  <= ash[i][30:0];
        e4_q[i]  <= dneg3_q[i] ? -epos[i] : epos[i];
        nd4_q[i] <= (act3_q == fdl_pkg::ACT_NORM_BOTH) ? nsc[i] : n3_q[i];
        b4_q[i]  <= nsc[i][15] ? nscn[i][15:0] : nsc[i];
      end
      fz4_q <= dzero3_q || ((act3_q == fdl_pkg::ACT_NORM_BOTH) && nzero3_q);

      act5_q <= act4_q;
      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= 62'(a4_q[i]) * 62'(a4_q[i]);
        nq5_q[i] <= 32'(b4_q[i]) * 32'(b4_q[i]);
        p5_q[i]  <= 48'(e4_q[i]) * 48'(nd4_q[i]);
      end
      fz5_q <= fz4_q;

      out_o.q      <= 64'(sq5_q[0]) + 64'(sq5_q[1]) + 64'(sq5_q[2]);
      out_o.qn     <= nq5_q[0] + nq5_q[1] + nq5_q[2];
      out_o.dot    <= 50'(p5_q[0]) + 50'(p5_q[1]) + 50'(p5_q[2]);
      out_o.action <= act5_q;
      out_o.fzero  <= fz5_q;
    end
  end

  assign valid_o = vld_q[5];

endmodule

`default_nettype wire

// ===== rtl/fdl_isqrt.sv =====
// ----------------------------------------------------------------------------
// fdl_isqrt
// Pipelined integer square roots of the light and normal length radicands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdl_isqrt (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [63:0]        q_i,
  input  wire logic [31:0]        qn_i,
  input  wire fdl_pkg::sq_side_t  side_i,
  output logic                    valid_o,
  output logic [31:0]             root_o,
  output logic [15:0]             nroot_o,
  output fdl_pkg::sq_side_t       side_o
);

  localparam int N = fdl_pkg::SQ_STAGES;

  fdl_pkg::sqrt_st_t sa_in;
  fdl_pkg::sqrt_st_t sb_in;
  fdl_pkg::sqrt_st_t sa_q   [N];
  fdl_pkg::sqrt_st_t sb_q   [N];
  fdl_pkg::sq_side_t side_q [N];
  logic [N-1:0]      vld_q;

  // the normal radicand is scaled by 2^32, its root then sits in the upper half
  assign sa_in = '{rem: q_i, root: '0};
  assign sb_in = '{rem: {qn_i, 32'b0}, root: '0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q[0]   <= fdl_pkg::sqrt_step(sa_in, N - 1);
      sb_q[0]   <= fdl_pkg::sqrt_step(sb_in, N - 1);
      side_q[0] <= side_i;
      for (int j = 1; j < N; j++) begin
        sa_q[j]   <= fdl_pkg::sqrt_step(sa_q[j-1], N - 1 - j);
        sb_q[j]   <= fdl_pkg::sqrt_step(sb_q[j-1], N - 1 - j);
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = sa_q[N-1].root;
  assign nroot_o = sb_q[N-1].root[31:16];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire

// ===== rtl/fdl_divide.sv =====
// ----------------------------------------------------------------------------
// fdl_divide
// Divisor product and pipelined restoring division of the light factor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fdl_divide (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [31:0]        root_i,
  input  wire logic [15:0]        nroot_i,
  input  wire fdl_pkg::sq_side_t  side_i,
  output logic                    valid_o,
  output logic [16:0]             quo_o,
  output fdl_pkg::div_side_t      side_o
);

  localparam int N = fdl_pkg::DIV_STAGES;

  logic signed [49:0] dneg;
  logic        [49:0] dmag;
  logic               norm;

  logic [63:0]         num_p_q;
  logic [47:0]         den_p_q;
  fdl_pkg::div_side_t  side_p_q;
  fdl_pkg::div_st_t    st_in;

  fdl_pkg::div_st_t    st_q   [N];
  logic [47:0]         den_q  [N];
  fdl_pkg::div_side_t  side_q [N];
  logic [N:0]          vld_q;

  always_comb begin
    dneg = -side_i.dot;
    dmag = side_i.dot[49] ? dneg : side_i.dot;
    norm = (side_i.action == fdl_pkg::ACT_NORM_BOTH);
  end

  assign st_in = '{rem: num_p_q, quo: '0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // factor is -32768*dot/(r*rn) or -2*dot/r, divide magnitudes
      num_p_q        <= norm ? (64'(dmag) << 15) : (64'(dmag) << 1);
      den_p_q        <= norm ? 48'(root_i) * 48'(nroot_i) : 48'(root_i);
      side_p_q.neg   <= !side_i.dot[49] && (side_i.dot != '0);
      side_p_q.action <= side_i.action;
      side_p_q.fzero <= side_i.fzero;

      st_q[0]   <= fdl_pkg::div_step(st_in, den_p_q, N - 1);
      den_q[0]  <= den_p_q;
      side_q[0] <= side_p_q;
      for (int j = 1; j < N; j++) begin
        st_q[j]   <= fdl_pkg::div_step(st_q[j-1], den_q[j-1], N - 1 - j);
        den_q[j]  <= den_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quo_o   = st_q[N-1].quo;
  assign side_o  = side_q[N-1];

  // the factor bound keeps the quotient inside its bits
  `FDL_ASSERT_IMPL(a_div_rem_below_den, clk_i, rst_ni, vld_q[N] && !side_q[N-1].fzero, st_q[N-1].rem < 64'(den_q[N-1]))

endmodule

`default_nettype wire

// ===== rtl/fdl_color.sv =====
// ----------------------------------------------------------------------------
// fdl_color
// Factor floor, offset, amplitude product and color saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdl_color (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [16:0]         quo_i,
  input  wire fdl_pkg::div_side_t  side_i,
  input  wire fdl_pkg::cfg_t       cfg_i,
  output logic                     valid_o,
  output logic [15:0]              color_o,
  output logic                     kind_o,
  output logic                     sat_o
);

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_NEG  = 2'd1,
    CLS_POS  = 2'd2,
    CLS_BASE = 2'd3
  } cls_e;

  logic signed [17:0] fq;
  logic signed [17:0] f;
  logic signed [17:0] fmin;
  logic               below;
  logic signed [17:0] fc;
  cls_e               cls;

  logic               v1_q, v2_q, v3_q;
  logic signed [32:0] s1_q;
  logic               base1_q, kind1_q;
  cls_e               cls2_q;
  logic [63:0]        prod2_q;
  logic               kind2_q;
  logic [15:0]        color_q;
  logic               kind_q, sat_q;

  always_comb begin
    fq    = {1'b0, quo_i};
    f     = side_i.fzero ? '0 : (side_i.neg ? -fq : fq);
    fmin  = 18'(cfg_i.min_factor);
    below = (f < fmin);
    fc    = below ? fmin : f;

    if (base1_q) begin
      cls = CLS_BASE;
    end else if ((s1_q == '0) || (cfg_i.light_amp == '0)) begin
      cls = CLS_ZERO;
    end else if (s1_q[32]) begin
      cls = CLS_NEG;
    end else begin
      cls = CLS_POS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q    <= 33'(fc) + 33'(cfg_i.light_offset);
      base1_q <= below && (side_i.action == fdl_pkg::ACT_BASE);
      kind1_q <= (side_i.action != fdl_pkg::ACT_NORM_BOTH);

      cls2_q  <= cls;
      prod2_q <= 64'(s1_q[31:0]) * 64'(cfg_i.light_amp);
      kind2_q <= kind1_q;

      kind_q <= kind2_q;
      unique case (cls2_q)
        CLS_BASE: begin
          color_q <= cfg_i.base_color;
          sat_q   <= 1'b0;
        end
        CLS_NEG: begin
          color_q <= '0;
          sat_q   <= 1'b1;
        end
        CLS_POS: begin
          // color is the product over 2^32
          if (prod2_q[63:48] != '0) begin
            color_q <= '1;
            sat_q   <= 1'b1;
          end else begin
            color_q <= prod2_q[47:32];
            sat_q   <= 1'b0;
          end
        end
        default: begin
          color_q <= '0;
          sat_q   <= 1'b0;
        end
      endcase
    end
  end

  assign valid_o = v3_q;
  assign color_o = color_q;
  assign kind_o  = kind_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire

// ===== rtl/flat_diffuse_light_shade.sv =====
// Stages: 6 front, 32 root, 18 divide and 3 color, from input transfer to result.
// Throughput: one polygon per cycle while the output is not stalled; the root and divide units take one bit per stage.
// The whole pipeline advances when the output register is empty or being taken.
// Reset: asynchronous active low, clears all valid bits and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// flat_diffuse_light_shade
// Flat per-polygon diffuse light factor and color with a config write channel.
// ----------------------------------------------------------------------------

`include "assert_macros.svh"

module flat_diffuse_light_shade (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z
  input  wire logic [143:0]  s_axis_tdata,
  // action
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // shade color
  output logic [15:0]        m_axis_tdata,
  // render_kind, saturated
  output logic [1:0]         m_axis_tuser,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_addr_i,
  input  wire logic [31:0]   cfg_data_i
);

  fdl_pkg::cfg_t       cfg_q;
  logic                adv;

  logic                front_valid;
  fdl_pkg::front_out_t front_out;
  fdl_pkg::sq_side_t   sq_side_in;

  logic                sq_valid;
  logic [31:0]         root;
  logic [15:0]         nroot;
  fdl_pkg::sq_side_t   sq_side;

  logic                div_valid;
  logic [16:0]         quo;
  fdl_pkg::div_side_t  div_side;

  logic [15:0]         color;
  logic                kind;
  logic                sat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (fdl_pkg::reg_idx_e'(cfg_addr_i))
        fdl_pkg::REG_LIGHT_X:      cfg_q.light_x      <= $signed(cfg_data_i);
        fdl_pkg::REG_LIGHT_Y:      cfg_q.light_y      <= $signed(cfg_data_i);
        fdl_pkg::REG_LIGHT_Z:      cfg_q.light_z      <= $signed(cfg_data_i);
        fdl_pkg::REG_LIGHT_OFFSET: cfg_q.light_offset <= $signed(cfg_data_i);
        fdl_pkg::REG_LIGHT_AMP:    cfg_q.light_amp    <= cfg_data_i;
        fdl_pkg::REG_BASE_COLOR:   cfg_q.base_color   <= cfg_data_i[15:0];
        fdl_pkg::REG_MIN_FACTOR:   cfg_q.min_factor   <= $signed(cfg_data_i[16:0]);
        default: ;
      endcase
    end
  end

  // pipeline freezes as a whole while the result waits
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  fdl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (s_axis_tvalid),
    .action_i   (fdl_pkg::action_e'(s_axis_tuser)),
    .vertex_x_i ($signed(s_axis_tdata[31:0])),
    .vertex_y_i ($signed(s_axis_tdata[63:32])),
    .vertex_z_i ($signed(s_axis_tdata[95:64])),
    .normal_x_i ($signed(s_axis_tdata[111:96])),
    .normal_y_i ($signed(s_axis_tdata[127:112])),
    .normal_z_i ($signed(s_axis_tdata[143:128])),
    .cfg_i      (cfg_q),
    .valid_o    (front_valid),
    .out_o      (front_out)
  );

  assign sq_side_in = '{dot: front_out.dot, action: front_out.action, fzero: front_out.fzero};

  fdl_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (front_valid),
    .q_i     (front_out.q),
    .qn_i    (front_out.qn),
    .side_i  (sq_side_in),
    .valid_o (sq_valid),
    .root_o  (root),
    .nroot_o (nroot),
    .side_o  (sq_side)
  );

  fdl_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_valid),
    .root_i  (root),
    .nroot_i (nroot),
    .side_i  (sq_side),
    .valid_o (div_valid),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  fdl_color u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (div_valid),
    .quo_i   (quo),
    .side_i  (div_side),
    .cfg_i   (cfg_q),
    .valid_o (m_axis_tvalid),
    .color_o (color),
    .kind_o  (kind),
    .sat_o   (sat)
  );

  assign m_axis_tdata = color;
  assign m_axis_tuser = {sat, kind};

  `FDL_ASSERT_IMPL(a_sat_on_rail, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1],
                   m_axis_tdata == 16'h0000 || m_axis_tdata == 16'hffff)
  `FDL_ASSERT_NEXT(a_frozen_result_holds, clk_i, rst_ni, !s_axis_tready,
                   $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

`default_nettype wire
